// ----- src/hscr_pkg.sv -----
// Shared types, constants and SHA-256 helper functions for the HMAC-SHA256
// counter-mode random generator. No dependencies.
package hscr_pkg;

	localparam int unsigned MAX_BYTES_DEF = 2048;
	localparam int unsigned CNT_W = 12;
	localparam int unsigned BLOCK_BYTES = 32;
	localparam int unsigned SEED_WORDS = 8;
	localparam int unsigned CFG_ADDR_W = 3;

	localparam logic [7:0] IPAD = 8'h36;
	localparam logic [7:0] OPAD = 8'h5C;

	// Midstate memory entries
	localparam logic MID_INNER = 1'b0;
	localparam logic MID_OUTER = 1'b1;

	typedef logic [31:0]  word_t;
	typedef logic [255:0] word256_t;
	typedef logic [511:0] word512_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	localparam word256_t HINIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	function automatic word_t bsig0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t ssig1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ----- src/hscr_if.sv -----
// Request and result channel interfaces (valid/ready).
// Depends on hscr_pkg.
interface hscr_req_if import hscr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] byte_count;

	modport source(output valid, output byte_count, input ready);
	modport sink(input valid, input byte_count, output ready);
endinterface

interface hscr_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word0;
	logic [63:0] digest_word1;
	logic [63:0] digest_word2;
	logic [63:0] digest_word3;
	logic [5:0]  valid_bytes;
	logic        last_block;

	modport source(output valid, output digest_word0, output digest_word1,
		output digest_word2, output digest_word3, output valid_bytes,
		output last_block, input ready);
	modport sink(input valid, input digest_word0, input digest_word1,
		input digest_word2, input digest_word3, input valid_bytes,
		input last_block, output ready);
endinterface

// ----- src/hscr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module hscr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/hscr_core.sv -----
// SHA-256 compression unit: one round per cycle, rolling 16-word schedule.
// Depends on hscr_pkg.
module hscr_core import hscr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  word256_t   init_state,
	input  word512_t   block,
	output word256_t   digest,
	output core_stat_t stat
);
	word_t    st_q [8];
	word_t    w_q [16];
	word256_t init_q;
	word256_t digest_q;
	logic [5:0] cnt_q;
	logic run_q, fin_q, done_q;

	word_t t1, t2, w_new;

	always_comb begin
		t1 = st_q[7] + bsig1(st_q[4]) + ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]))
			+ K_TAB[cnt_q] + w_q[0];
		t2 = bsig0(st_q[0]) + ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2])
			^ (st_q[1] & st_q[2]));
		w_new = w_q[0] + ssig0(w_q[1]) + w_q[9] + ssig1(w_q[14]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && (cnt_q == 6'd63);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			init_q <= init_state;
			for (int i = 0; i < 8; i++) begin
				st_q[i] <= init_state[255-32*i -: 32];
			end
			for (int j = 0; j < 16; j++) begin
				w_q[j] <= block[511-32*j -: 32];
			end
		end else if (run_q) begin
			st_q[0] <= t1 + t2;
			st_q[1] <= st_q[0];
			st_q[2] <= st_q[1];
			st_q[3] <= st_q[2];
			st_q[4] <= st_q[3] + t1;
			st_q[5] <= st_q[4];
			st_q[6] <= st_q[5];
			st_q[7] <= st_q[6];
			for (int j = 0; j < 15; j++) begin
				w_q[j] <= w_q[j+1];
			end
			w_q[15] <= w_new;
		end
		if (fin_q) begin
			for (int i = 0; i < 8; i++) begin
				digest_q[255-32*i -: 32] <= init_q[255-32*i -: 32] + st_q[i];
			end
		end
	end

	assign digest    = digest_q;
	assign stat.busy = run_q | fin_q;
	assign stat.done = done_q;
endmodule

// ----- src/hmac_sha256_counter_random_top.sv -----
// Top level: HMAC-SHA256 counter-mode random generator, request sequencer.
// Depends on hscr_pkg, hscr_if, hscr_ram, hscr_core.
//
// Channel  Dir  Fields
// req      in   byte_count
// rsp      out  digest_word0..3, valid_bytes, last_block
// cfg      in   cfg_we, cfg_addr, cfg_wdata (seed words 0..7)
//
// Each 32-byte block takes two compressions in the round unit, one midstate
// memory read before each, and a load of the result register.
// After reset or a seed write, the first request also recomputes the inner
// and outer key midstates into the midstate memory.
// One request at a time; the result register lets the next block start
// while a finished block waits for rsp.ready.
module hmac_sha256_counter_random_top import hscr_pkg::*; #(
	parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hscr_req_if.sink              req,
	hscr_rsp_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [63:0]           cfg_wdata
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_PRE_I = 8'b0000_0010,
		ST_PRE_O = 8'b0000_0100,
		ST_RD_I  = 8'b0000_1000,
		ST_INNER = 8'b0001_0000,
		ST_RD_O  = 8'b0010_0000,
		ST_OUTER = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	localparam logic [CNT_W-1:0] MAX_LIM = CNT_W'(MAX_BYTES);
	localparam logic [CNT_W-1:0] BLK_LIM = CNT_W'(BLOCK_BYTES);

	state_t state_q;
	logic [63:0] seed_q [SEED_WORDS];
	logic        dirty_q;
	logic [63:0] ctr_q;
	logic [CNT_W-1:0] rem_q;
	logic        start_q;
	word256_t    inner_q;
	logic        out_v_q;
	word256_t    out_dig_q;
	logic [5:0]  out_vb_q;
	logic        out_last_q;

	word512_t   key_blk, core_blk, seed_cat;
	word256_t   core_init, core_dig, mid_rdata;
	core_stat_t core_st;
	logic       ram_we, ram_raddr, emit_go, req_go;
	logic [CNT_W-1:0] req_bytes, take, rem_nxt;

	always_comb begin
		for (int i = 0; i < SEED_WORDS; i++) begin
			seed_cat[511-64*i -: 64] = seed_q[i];
		end
	end

	always_comb begin
		key_blk   = seed_cat ^ {64{IPAD}};
		core_blk  = key_blk;
		core_init = HINIT;
		case (state_q)
			ST_PRE_O: key_blk = seed_cat ^ {64{OPAD}};
			default: ;
		endcase
		case (state_q)
			ST_PRE_I, ST_PRE_O: begin
				core_blk  = key_blk;
				core_init = HINIT;
			end
			ST_INNER: begin
				// counter as eight little-endian bytes, padding, length 72 bytes
				core_blk = {ctr_q[7:0], ctr_q[15:8], ctr_q[23:16], ctr_q[31:24],
					ctr_q[39:32], ctr_q[47:40], ctr_q[55:48], ctr_q[63:56],
					32'h8000_0000, 384'b0, 32'h0000_0240};
				core_init = mid_rdata;
			end
			ST_OUTER: begin
				core_blk  = {inner_q, 32'h8000_0000, 192'b0, 32'h0000_0300};
				core_init = mid_rdata;
			end
			default: ;
		endcase
	end

	assign req_bytes = (req.byte_count > MAX_LIM) ? MAX_LIM : req.byte_count;
	assign take      = (rem_q > BLK_LIM) ? BLK_LIM : rem_q;
	assign rem_nxt   = rem_q - take;
	assign req_go    = req.valid && req.ready;
	assign emit_go   = (state_q == ST_EMIT) && (!out_v_q || rsp.ready);
	assign ram_we    = core_st.done && ((state_q == ST_PRE_I) || (state_q == ST_PRE_O));
	assign ram_raddr = (state_q == ST_RD_O) ? MID_OUTER : MID_INNER;

	hscr_ram #(.WIDTH(256), .DEPTH(2)) u_mid (
		.clk   (clk),
		.we    (ram_we),
		.waddr ((state_q == ST_PRE_O) ? MID_OUTER : MID_INNER),
		.wdata (core_dig),
		.raddr (ram_raddr),
		.rdata (mid_rdata)
	);

	hscr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start_q),
		.init_state (core_init),
		.block      (core_blk),
		.digest     (core_dig),
		.stat       (core_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b1;
			ctr_q   <= '0;
			rem_q   <= '0;
			start_q <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < SEED_WORDS; i++) begin
				seed_q[i] <= '0;
			end
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				seed_q[cfg_addr] <= cfg_wdata;
				dirty_q <= 1'b1;
			end
			if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_go && (req_bytes != '0)) begin
						rem_q <= req_bytes;
						if (dirty_q) begin
							state_q <= ST_PRE_I;
							start_q <= 1'b1;
						end else begin
							state_q <= ST_RD_I;
						end
					end
				end
				ST_PRE_I: begin
					if (core_st.done) begin
						state_q <= ST_PRE_O;
						start_q <= 1'b1;
					end
				end
				ST_PRE_O: begin
					if (core_st.done) begin
						state_q <= ST_RD_I;
						dirty_q <= 1'b0;
					end
				end
				ST_RD_I: begin
					state_q <= ST_INNER;
					start_q <= 1'b1;
				end
				ST_INNER: begin
					if (core_st.done) begin
						state_q <= ST_RD_O;
					end
				end
				ST_RD_O: begin
					state_q <= ST_OUTER;
					start_q <= 1'b1;
				end
				ST_OUTER: begin
					if (core_st.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_v_q <= 1'b1;
						ctr_q   <= ctr_q + 64'd1;
						rem_q   <= rem_nxt;
						state_q <= (rem_nxt == '0) ? ST_IDLE : ST_RD_I;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INNER && core_st.done) begin
			inner_q <= core_dig;
		end
		if (emit_go) begin
			out_dig_q  <= core_dig;
			out_vb_q   <= take[5:0];
			out_last_q <= (rem_nxt == '0);
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = out_v_q;
	assign rsp.digest_word0 = out_dig_q[255:192];
	assign rsp.digest_word1 = out_dig_q[191:128];
	assign rsp.digest_word2 = out_dig_q[127:64];
	assign rsp.digest_word3 = out_dig_q[63:0];
	assign rsp.valid_bytes  = out_vb_q;
	assign rsp.last_block   = out_last_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !core_st.busy)
		else $error("round unit started while busy");

	a_emit_rem: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> (rem_q != '0))
		else $error("block emitted with no bytes remaining");

	a_req_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_go && (req.byte_count != '0)) |=> (state_q != ST_IDLE))
		else $error("nonzero request did not start");

	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (ctr_q == $past(ctr_q) + 64'd1))
		else $error("block counter did not advance by one");
endmodule
